### design/set_assoc_cache_lru_lookup_macros.svh
// Assertion macros for the set-associative cache lookup block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`ifndef ASSERT_OFF
`define SLCL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SLCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SLCL_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SLCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/slcl_pkg.sv
// Shared types and constants of the set-associative cache lookup block.
// No dependencies.
`default_nettype none
package slcl_pkg;
    localparam int MAX_WAYS = 8;
    localparam int MAX_SETS = 256;
    localparam int SET_W    = $clog2(MAX_SETS);
    localparam int WAY_W    = $clog2(MAX_WAYS);
    localparam int RANK_W   = WAY_W;
    localparam int ADDR_W   = 32;
    localparam int TAG_W    = ADDR_W;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYS = 2'd0,
        CFG_SETB = 2'd1,
        CFG_OFFB = 2'd2
    } t_cfg_idx;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]  t_tags;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0] t_ranks;

    typedef struct packed {
        logic [MAX_WAYS-1:0] vld;
        t_ranks              rank;
    } t_meta;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } t_look;
endpackage
`default_nettype wire

### design/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative cache tag store with rank-based LRU.
// Depends on slcl_pkg, slcl_tag_ram, slcl_meta_ram, slcl_lookup, slcl_rank_upd.
//
//   channel   direction  handshake                    payload
//   addr      in         i_addr_valid / o_addr_ready  i_address
//   res       out        o_res_valid / i_res_ready    o_hit o_way_used o_miss_total o_access_total
//   cfg       in         i_cfg_we                     i_cfg_idx i_cfg_wdata
//
// Each item passes through tag and meta memory read, tag compare, then rank
// update with write-back, as a read-modify-write of one set row.
// The next item is taken while the result waits in the output register.
// A stalled result holds the write-back cycle until the output register frees.
// Valid bits and ranks read as zero until a set is written.
`default_nettype none
`include "set_assoc_cache_lru_lookup_macros.svh"
module set_assoc_cache_lru_lookup (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_addr_valid,
    output logic                               o_addr_ready,
    input  wire logic [slcl_pkg::ADDR_W-1:0]   i_address,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic                               o_hit,
    output logic [slcl_pkg::WAY_W-1:0]         o_way_used,
    output logic [slcl_pkg::CNT_W-1:0]         o_miss_total,
    output logic [slcl_pkg::CNT_W-1:0]         o_access_total,
    input  wire logic                          i_cfg_we,
    input  wire logic [slcl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [slcl_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import slcl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_UPD  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_ways_cfg, r_setb_cfg, r_offb_cfg;
    logic [CFG_W-1:0] r_ways;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_hit;
    logic [WAY_W-1:0] r_way;
    logic [CNT_W-1:0] r_miss_cnt, r_acc_cnt;
    logic             r_res_vld;
    logic             r_out_hit;
    logic [WAY_W-1:0] r_out_way;
    logic [CNT_W-1:0] r_out_miss, r_out_acc;

    logic             accept;
    logic             upd_go;
    logic [CFG_W-1:0] sbits_eff;
    logic [CFG_W-1:0] ways_eff;
    logic [SET_W-1:0] set_mask;
    logic [ADDR_W-1:0] addr_sh;
    logic [SET_W-1:0] acc_set;
    logic [CFG_W:0]   tag_shift;
    logic [TAG_W-1:0] acc_tag;
    logic [CNT_W-1:0] n_miss_cnt, n_acc_cnt;
    logic [MAX_WAYS-1:0] way_oh;
    t_tags            tag_rd;
    t_meta            meta_rd;
    t_meta            meta_wr;
    t_look            look;
    t_ranks           new_rank;

    assign o_addr_ready = (r_state == ST_IDLE);
    assign accept       = i_addr_valid && o_addr_ready;
    assign upd_go       = (r_state == ST_UPD) && (!r_res_vld || i_res_ready);

    always_comb begin
        sbits_eff = (r_setb_cfg > CFG_W'(SET_W)) ? CFG_W'(SET_W) : r_setb_cfg;
        if (r_ways_cfg == '0) begin
            ways_eff = CFG_W'(1);
        end else if (r_ways_cfg > CFG_W'(MAX_WAYS)) begin
            ways_eff = CFG_W'(MAX_WAYS);
        end else begin
            ways_eff = r_ways_cfg;
        end
        set_mask  = ~({SET_W{1'b1}} << sbits_eff);
        addr_sh   = i_address >> r_offb_cfg;
        acc_set   = addr_sh[SET_W-1:0] & set_mask;
        tag_shift = {1'b0, r_offb_cfg} + {1'b0, sbits_eff};
        acc_tag   = i_address >> tag_shift;
        n_miss_cnt = r_miss_cnt + CNT_W'(!r_hit);
        n_acc_cnt  = r_acc_cnt + CNT_W'(1);
        way_oh     = MAX_WAYS'(1) << r_way;
        meta_wr.vld  = meta_rd.vld | way_oh;
        meta_wr.rank = new_rank;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_UPD;
            ST_UPD:  if (upd_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    slcl_tag_ram u_tag_ram (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (acc_set),
        .o_rdata (tag_rd),
        .i_we    (upd_go && !r_hit),
        .i_waddr (r_set),
        .i_wway  (r_way),
        .i_wdata (r_tag)
    );

    slcl_meta_ram u_meta_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_raddr (acc_set),
        .o_rdata (meta_rd),
        .i_we    (upd_go),
        .i_waddr (r_set),
        .i_wdata (meta_wr)
    );

    slcl_lookup u_lookup (
        .i_tags (tag_rd),
        .i_meta (meta_rd),
        .i_tag  (r_tag),
        .i_ways (r_ways),
        .o_look (look)
    );

    slcl_rank_upd u_rank_upd (
        .i_rank (meta_rd.rank),
        .i_ways (r_ways),
        .i_way  (r_way),
        .o_rank (new_rank)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ways_cfg <= CFG_W'(1);
            r_setb_cfg <= '0;
            r_offb_cfg <= CFG_W'(2);
            r_miss_cnt <= '0;
            r_acc_cnt  <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WAYS: r_ways_cfg <= i_cfg_wdata;
                    CFG_SETB: r_setb_cfg <= i_cfg_wdata;
                    CFG_OFFB: r_offb_cfg <= i_cfg_wdata;
                    default:  ;
                endcase
            end
            if (upd_go) begin
                r_miss_cnt <= n_miss_cnt;
                r_acc_cnt  <= n_acc_cnt;
                r_res_vld  <= 1'b1;
            end else if (i_res_ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ways <= ways_eff;
            r_set  <= acc_set;
            r_tag  <= acc_tag;
        end
        if (r_state == ST_LOOK) begin
            r_hit <= look.hit;
            r_way <= look.way;
        end
        if (upd_go) begin
            r_out_hit  <= r_hit;
            r_out_way  <= r_way;
            r_out_miss <= n_miss_cnt;
            r_out_acc  <= n_acc_cnt;
        end
    end

    assign o_res_valid    = r_res_vld;
    assign o_hit          = r_out_hit;
    assign o_way_used     = r_out_way;
    assign o_miss_total   = r_out_miss;
    assign o_access_total = r_out_acc;

    `SLCL_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, accept, r_state == ST_LOOK)
    `SLCL_ASSERT_NEXT(a_acc_count_step, i_clk, i_rst_n, upd_go, r_acc_cnt == $past(r_acc_cnt) + CNT_W'(1))
    `SLCL_ASSERT_NEXT(a_hit_keeps_miss, i_clk, i_rst_n, upd_go && r_hit, r_miss_cnt == $past(r_miss_cnt))
    `SLCL_ASSERT_SAME(a_upd_output_free, i_clk, i_rst_n, upd_go, !o_res_valid || i_res_ready)
endmodule
`default_nettype wire

### design/slcl_tag_ram.sv
// Tag memory: one row of tags per set, row read, single-way write.
// Depends on slcl_pkg.
`default_nettype none
module slcl_tag_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_re,
    input  wire logic [slcl_pkg::SET_W-1:0] i_raddr,
    output slcl_pkg::t_tags                o_rdata,
    input  wire logic                      i_we,
    input  wire logic [slcl_pkg::SET_W-1:0] i_waddr,
    input  wire logic [slcl_pkg::WAY_W-1:0] i_wway,
    input  wire logic [slcl_pkg::TAG_W-1:0] i_wdata
);
    import slcl_pkg::*;

    logic [TAG_W-1:0] r_mem [MAX_SETS][MAX_WAYS];
    t_tags            r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wway] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                r_rdata[w] <= r_mem[i_raddr][w];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### design/slcl_meta_ram.sv
// Valid and rank memory, one row per set; a row never written reads as zero.
// Depends on slcl_pkg.
`default_nettype none
module slcl_meta_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_re,
    input  wire logic [slcl_pkg::SET_W-1:0] i_raddr,
    output slcl_pkg::t_meta                o_rdata,
    input  wire logic                      i_we,
    input  wire logic [slcl_pkg::SET_W-1:0] i_waddr,
    input  wire slcl_pkg::t_meta           i_wdata
);
    import slcl_pkg::*;

    t_meta               r_mem [MAX_SETS];
    logic [MAX_SETS-1:0] r_row_vld;
    t_meta               r_rdata;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_row_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;
endmodule
`default_nettype wire

### design/slcl_lookup.sv
// Tag match and victim choice over the ways of one set.
// Depends on slcl_pkg.
`default_nettype none
module slcl_lookup (
    input  wire slcl_pkg::t_tags            i_tags,
    input  wire slcl_pkg::t_meta            i_meta,
    input  wire logic [slcl_pkg::TAG_W-1:0] i_tag,
    input  wire logic [slcl_pkg::CFG_W-1:0] i_ways,
    output slcl_pkg::t_look                 o_look
);
    import slcl_pkg::*;

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] empty;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    min_way;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = CFG_W'(w) < i_ways;
            match[w]  = in_use[w] && i_meta.vld[w] && (i_tags[w] == i_tag);
            empty[w]  = in_use[w] && !i_meta.vld[w];
        end
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (empty[w]) begin
                free_way = WAY_W'(w);
            end
        end
        min_way = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (i_meta.rank[w] < i_meta.rank[min_way])) begin
                min_way = WAY_W'(w);
            end
        end
        o_look.hit = |match;
        if (|match) begin
            o_look.way = hit_way;
        end else if (|empty) begin
            o_look.way = free_way;
        end else begin
            o_look.way = min_way;
        end
    end
endmodule
`default_nettype wire

### design/slcl_rank_upd.sv
// Recency rank update of one set after an access.
// Depends on slcl_pkg.
`default_nettype none
module slcl_rank_upd (
    input  wire slcl_pkg::t_ranks           i_rank,
    input  wire logic [slcl_pkg::CFG_W-1:0] i_ways,
    input  wire logic [slcl_pkg::WAY_W-1:0] i_way,
    output slcl_pkg::t_ranks                o_rank
);
    import slcl_pkg::*;

    logic [MAX_WAYS-1:0] in_use;
    logic [RANK_W-1:0]   top;
    logic [RANK_W-1:0]   old;
    logic [RANK_W-1:0]   ways_m1;

    always_comb begin
        top = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = CFG_W'(w) < i_ways;
            if (in_use[w] && (i_rank[w] > top)) begin
                top = i_rank[w];
            end
        end
        old     = i_rank[i_way];
        ways_m1 = RANK_W'(i_ways - CFG_W'(1));
        o_rank  = i_rank;
        if (i_ways > CFG_W'(1)) begin
            if (top < ways_m1) begin
                o_rank[i_way] = top + RANK_W'(1);
            end else begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (in_use[w] && (WAY_W'(w) != i_way) && (i_rank[w] > old)) begin
                        o_rank[w] = i_rank[w] - RANK_W'(1);
                    end
                end
                o_rank[i_way] = ways_m1;
            end
        end
    end
endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the set-associative cache lookup with rank-based LRU.
// Holds its own tag/valid/rank mirror to predict every lookup result.
// Depends on slcl_pkg and set_assoc_cache_lru_lookup.
`timescale 1ns / 100ps
module testbench;
    import slcl_pkg::*;

    localparam int IDLE_PCT     = 19;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 132;
    localparam int N_PHASES     = 14;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] accesses;
    } t_lookup_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_addr_valid = 1'b0;
    logic                 o_addr_ready;
    logic [ADDR_W-1:0]    i_address = '0;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic                 o_hit;
    logic [WAY_W-1:0]     o_way_used;
    logic [CNT_W-1:0]     o_miss_total;
    logic [CNT_W-1:0]     o_access_total;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    logic [ADDR_W-1:0] pending_addrs[$];
    t_lookup_res       expected_lookups[$];

    logic [TAG_W-1:0]  tag_mem  [MAX_SETS][MAX_WAYS];
    bit                vld_mem  [MAX_SETS][MAX_WAYS];
    bit [RANK_W-1:0]   rank_mem [MAX_SETS][MAX_WAYS];
    logic [CNT_W-1:0]  miss_count = '0;
    logic [CNT_W-1:0]  access_count = '0;
    logic [CFG_W-1:0]  ways_cfg = 4'd1;
    logic [CFG_W-1:0]  setb_cfg = 4'd0;
    logic [CFG_W-1:0]  offb_cfg = 4'd2;

    bit addr_taken = 1'b0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int lookups_checked = 0;
    int hits_checked = 0;
    int settings_run = 0;

    set_assoc_cache_lru_lookup i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_addr_valid   (i_addr_valid),
        .o_addr_ready   (o_addr_ready),
        .i_address      (i_address),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_hit          (o_hit),
        .o_way_used     (o_way_used),
        .o_miss_total   (o_miss_total),
        .o_access_total (o_access_total),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_set_bits();
        return (setb_cfg > 8) ? 8 : int'(setb_cfg);
    endfunction

    function automatic t_lookup_res cache_lookup(input logic [ADDR_W-1:0] addr);
        int ways;
        int sbits;
        int obits;
        int set_idx;
        int way;
        int top;
        int old_rank;
        logic [TAG_W-1:0] tag;
        logic [31:0] set_mask;
        bit hit;
        bit found;
        t_lookup_res res;
        ways = (ways_cfg < 1) ? 1 : (ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg);
        sbits = eff_set_bits();
        obits = int'(offb_cfg);
        set_mask = (32'd1 << sbits) - 32'd1;
        set_idx = int'(((addr >> obits) & set_mask) % MAX_SETS);
        tag = addr >> (obits + sbits);
        hit = 1'b0;
        found = 1'b0;
        way = 0;
        for (int w = 0; w < ways; w++) begin
            if (!hit && vld_mem[set_idx][w] && tag_mem[set_idx][w] == tag) begin
                hit = 1'b1;
                way = w;
            end
        end
        if (!hit) begin
            for (int w = 0; w < ways; w++) begin
                if (!found && !vld_mem[set_idx][w]) begin
                    found = 1'b1;
                    way = w;
                end
            end
            if (!found) begin
                way = 0;
                for (int w = 1; w < ways; w++)
                    if (rank_mem[set_idx][w] < rank_mem[set_idx][way])
                        way = w;
            end
            tag_mem[set_idx][way] = tag;
            vld_mem[set_idx][way] = 1'b1;
            miss_count = miss_count + 1;
        end
        if (ways > 1) begin
            old_rank = int'(rank_mem[set_idx][way]);
            top = 0;
            for (int w = 0; w < ways; w++)
                if (int'(rank_mem[set_idx][w]) > top)
                    top = int'(rank_mem[set_idx][w]);
            if (top < ways - 1) begin
                rank_mem[set_idx][way] = RANK_W'(top + 1);
            end else begin
                rank_mem[set_idx][way] = RANK_W'(ways - 1);
                for (int w = 0; w < ways; w++)
                    if (w != way && int'(rank_mem[set_idx][w]) > old_rank)
                        rank_mem[set_idx][w] = rank_mem[set_idx][w] - RANK_W'(1);
            end
        end
        access_count = access_count + 1;
        res.hit = hit;
        res.way = WAY_W'(way);
        res.misses = miss_count;
        res.accesses = access_count;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] make_addr(input logic [31:0] tag,
                                                    input logic [31:0] set_sel,
                                                    input logic [31:0] off);
        int sbits;
        int obits;
        sbits = eff_set_bits();
        obits = int'(offb_cfg);
        return (tag << (obits + sbits)) | ((set_sel & ((32'd1 << sbits) - 32'd1)) << obits)
               | (off & ((32'd1 << obits) - 32'd1));
    endfunction

    // Sender: hold the item until accepted, otherwise idle or offer the next one.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_addr_valid || addr_taken)) begin
            addr_taken = 1'b0;
            if (pending_addrs.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                i_address <= pending_addrs.pop_front();
                i_addr_valid <= 1'b1;
            end else begin
                i_addr_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_res_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : lookup_monitor
        t_lookup_res want;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                if (expected_lookups.size() == 0) begin
                    $error("result with no access pending: hit %0d way %0d", o_hit, o_way_used);
                    mismatch_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    lookups_checked++;
                    if (o_hit) hits_checked++;
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        mismatch_count++;
                    end
                    if (o_way_used !== want.way) begin
                        $error("way_used: expected %0d, got %0d", want.way, o_way_used);
                        mismatch_count++;
                    end
                    if (o_miss_total !== want.misses) begin
                        $error("miss_total: expected %0d, got %0d", want.misses, o_miss_total);
                        mismatch_count++;
                    end
                    if (o_access_total !== want.accesses) begin
                        $error("access_total: expected %0d, got %0d",
                               want.accesses, o_access_total);
                        mismatch_count++;
                    end
                end
            end
            if (i_addr_valid && o_addr_ready) begin
                expected_lookups.push_back(cache_lookup(i_address));
                addr_taken = 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_addrs.size() > 0 || i_addr_valid || expected_lookups.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WAYS: ways_cfg = val;
            CFG_SETB: setb_cfg = val;
            CFG_OFFB: offb_cfg = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] s,
                                input logic [CFG_W-1:0] o);
        wait_drained();
        write_reg(CFG_WAYS, w);
        write_reg(CFG_SETB, s);
        write_reg(CFG_OFFB, o);
        settings_run++;
    endtask

    task automatic directed_items();
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'hFFFF_FFFF);
        pending_addrs.push_back(32'hFFFF_FFFF);
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'h5555_5555);
        pending_addrs.push_back(32'hAAAA_AAAA);
        // fill all eight ways of one set, then touch the first four
        apply_config(4'd8, 4'd2, 4'd0);
        for (int i = 0; i < 8; i++)
            pending_addrs.push_back(make_addr(32'hA0 + 32'(i), 0, 0));
        for (int i = 0; i < 4; i++)
            pending_addrs.push_back(make_addr(32'hA0 + 32'(i), 0, 0));
        // fewer ways: no rank-zero way left among them on the next miss
        wait_drained();
        write_reg(CFG_WAYS, 4'd4);
        pending_addrs.push_back(make_addr(32'hB5, 0, 0));
        // out-of-range register values
        apply_config(4'd0, 4'd15, 4'd15);
        pending_addrs.push_back($urandom);
        pending_addrs.push_back(32'hFFFF_FFFF);
        apply_config(4'd12, 4'd9, 4'd13);
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'h0000_0000);
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] s,
                                input logic [CFG_W-1:0] o);
        logic [31:0] tag_pool [10];
        logic [31:0] set_pool [4];
        int pool_n;
        apply_config(w, s, o);
        pool_n = ((w < 1) ? 1 : (w > MAX_WAYS) ? MAX_WAYS : int'(w)) + 2;
        foreach (tag_pool[i]) tag_pool[i] = $urandom;
        foreach (set_pool[i]) set_pool[i] = $urandom;
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 80)
                pending_addrs.push_back(make_addr(tag_pool[$urandom_range(pool_n - 1)],
                                                  set_pool[$urandom_range(3)], $urandom));
            else
                pending_addrs.push_back($urandom);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] fixed_cfg [7][3];
        fixed_cfg = '{'{4'd1, 4'd0, 4'd0}, '{4'd8, 4'd8, 4'd12}, '{4'd8, 4'd0, 4'd0},
                      '{4'd2, 4'd1, 4'd15}, '{4'd0, 4'd9, 4'd13}, '{4'd15, 4'd15, 4'd15},
                      '{4'd4, 4'd3, 4'd5}};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_items();
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 2) hold_req = 1'b1;
            if (p < 7)
                random_phase(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2]);
            else
                random_phase(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
                             CFG_W'($urandom_range(15)));
            if (p == 4) begin
                quiet = 1'b1;
                wait_drained();
                quiet = 1'b0;
            end
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d lookups (%0d hits) over %0d cache settings,", lookups_checked,
                 hits_checked, settings_run);
        $display("with random stalls, a long result hold-off and a back-to-back stretch.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting for lookup results");
        $display("Simulation FAILED");
        $finish;
    end
endmodule
